// ===== rtl/core/bayer_half_size_demosaic_macros.svh =====
// assertion macros for the half-size demosaic checker
`ifndef BAYER_HALF_SIZE_DEMOSAIC_MACROS_SVH
`define BAYER_HALF_SIZE_DEMOSAIC_MACROS_SVH

// same-cycle implication, checked outside reset
`define BHSD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bhsd assertion failed");

// next-cycle implication, checked outside reset
`define BHSD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bhsd assertion failed");

`endif

// ===== rtl/core/bhsd_pkg.sv =====
package bhsd_pkg;

    localparam int MAX_WIDTH_DEFAULT   = 4096;
    localparam int SAMPLE_BITS_DEFAULT = 16;

    localparam int FIELD_BITS  = 16;
    localparam int PATTERN_BITS = 32;
    localparam int WIDTH_BITS   = 13;
    localparam int HEIGHT_BITS  = 16;

    localparam logic [PATTERN_BITS-1:0] PATTERN_RESET = 32'h9494_9494;
    localparam logic [WIDTH_BITS-1:0]   WIDTH_RESET   = 13'd4096;
    localparam logic [HEIGHT_BITS-1:0]  HEIGHT_RESET  = 16'd4096;

    typedef enum logic [1:0] {
        CFG_PATTERN = 2'd0,
        CFG_WIDTH   = 2'd1,
        CFG_HEIGHT  = 2'd2
    } cfg_index_t;

    // filter codes in the pattern word
    localparam logic [1:0] CFA_RED  = 2'd0;
    localparam logic [1:0] CFA_BLUE = 2'd2;

    // channel numbers
    localparam logic [1:0] CH_RED   = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_BLUE  = 2'd2;

    typedef struct packed {
        logic valid;
        logic last;
    } bhsd_ctl_t;

endpackage

// ===== rtl/core/bhsd_line_mem.sv =====
module bhsd_line_mem #(
    parameter int ADDR_W = 11,
    parameter int DATA_W = 57
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [DATA_W-1:0] line_mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            line_mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= line_mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/bhsd_front.sv =====
module bhsd_front #(
    parameter int MAX_WIDTH   = 4096,
    parameter int SAMPLE_BITS = 16,
    parameter int ADDR_W      = $clog2(MAX_WIDTH) - 1,
    parameter int ENTRY_W     = 3 * (SAMPLE_BITS + 1) + 6
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic [bhsd_pkg::PATTERN_BITS-1:0]    cfa_pattern,
    input  logic [bhsd_pkg::WIDTH_BITS-1:0]      image_width,
    input  logic [bhsd_pkg::HEIGHT_BITS-1:0]     image_height,
    input  logic                                 accept,
    input  logic                                 adv,
    input  logic [bhsd_pkg::FIELD_BITS-1:0]      red_sample,
    input  logic [bhsd_pkg::FIELD_BITS-1:0]      green_sample,
    input  logic [bhsd_pkg::FIELD_BITS-1:0]      blue_sample,
    output logic                                 mem_we,
    output logic                                 mem_re,
    output logic [ADDR_W-1:0]                    mem_waddr,
    output logic [ADDR_W-1:0]                    mem_raddr,
    output logic [ENTRY_W-1:0]                   mem_wdata,
    output bhsd_pkg::bhsd_ctl_t                  s1_ctl,
    output logic [ENTRY_W-1:0]                   s1_pair
);

    import bhsd_pkg::*;

    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int EW   = CW + 1;
    localparam int GW   = (EW > WIDTH_BITS) ? EW : WIDTH_BITS;
    localparam int PS_W = SAMPLE_BITS + 1;
    localparam int HW   = HEIGHT_BITS;

    logic [CW-1:0]             col_reg;
    logic [HW-1:0]             row_reg;
    logic [2:0][PS_W-1:0]      pair_sum_reg;
    logic [2:0][1:0]           pair_cnt_reg;
    bhsd_ctl_t                 s1_ctl_reg;
    logic [ENTRY_W-1:0]        s1_pair_reg;

    logic [GW-1:0]             w_ext;
    logic [GW-1:0]             max_w;
    logic [GW-1:0]             w_eff;
    logic [GW-1:0]             col_inc;
    logic [HW-1:0]             h_eff;
    logic [HW-1:0]             row_tmp;
    logic [HW-1:0]             row_cur;
    logic [HW-1:0]             row_inc;
    logic [CW-1:0]             col_cur;
    logic                      col_wrap;
    logic                      last;
    logic [3:0]                pos_idx;
    logic [1:0]                color;
    logic [1:0]                ch;
    logic [SAMPLE_BITS-1:0]    sample;
    logic [CW-1:0]             col_next;
    logic [HW-1:0]             row_next;
    logic [2:0][PS_W-1:0]      pair_sum_next;
    logic [2:0][1:0]           pair_cnt_next;
    logic [ENTRY_W-1:0]        pair_entry;
    logic                      s1_valid_next;

    always_comb
    begin
        w_ext = GW'(image_width);
        max_w = GW'(MAX_WIDTH);
        if (w_ext < GW'(2))
        begin
            w_eff = GW'(2);
        end
        else if (w_ext > max_w)
        begin
            w_eff = max_w;
        end
        else
        begin
            w_eff = w_ext;
        end
        h_eff = (image_height < HW'(2)) ? HW'(2) : image_height;

        // wrap a position left behind by a geometry change
        col_wrap = GW'(col_reg) >= w_eff;
        col_cur  = col_wrap ? '0 : col_reg;
        row_tmp  = col_wrap ? row_reg + HW'(1) : row_reg;
        row_cur  = (row_tmp >= h_eff) ? '0 : row_tmp;

        pos_idx = {row_cur[2:0], col_cur[0]};
        color   = cfa_pattern[{pos_idx, 1'b0} +: 2];
        case (color)
            CFA_RED:  ch = CH_RED;
            CFA_BLUE: ch = CH_BLUE;
            default:  ch = CH_GREEN;
        endcase
        case (ch)
            CH_RED:  sample = red_sample[SAMPLE_BITS-1:0];
            CH_BLUE: sample = blue_sample[SAMPLE_BITS-1:0];
            default: sample = green_sample[SAMPLE_BITS-1:0];
        endcase

        for (int i = 0; i < 3; i++)
        begin
            pair_sum_next[i] = col_cur[0] ? pair_sum_reg[i] : '0;
            pair_cnt_next[i] = col_cur[0] ? pair_cnt_reg[i] : '0;
            if (ch == 2'(i))
            begin
                pair_sum_next[i] = pair_sum_next[i] + PS_W'(sample);
                pair_cnt_next[i] = pair_cnt_next[i] + 2'd1;
            end
        end
        pair_entry = {pair_cnt_next, pair_sum_next};

        last = (row_cur == ((h_eff & ~HW'(1)) - HW'(1)))
            && (GW'(col_cur) == ((w_eff & ~GW'(1)) - GW'(1)));

        col_inc = GW'(col_cur) + GW'(1);
        row_inc = row_cur + HW'(1);
        if (col_inc >= w_eff)
        begin
            col_next = '0;
            row_next = (row_inc >= h_eff) ? '0 : row_inc;
        end
        else
        begin
            col_next = col_inc[CW-1:0];
            row_next = row_cur;
        end

        s1_valid_next = accept && col_cur[0] && row_cur[0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            pair_sum_reg <= '0;
            pair_cnt_reg <= '0;
            s1_ctl_reg   <= '0;
        end
        else
        begin
            if (accept)
            begin
                col_reg      <= col_next;
                row_reg      <= row_next;
                pair_sum_reg <= pair_sum_next;
                pair_cnt_reg <= pair_cnt_next;
            end
            if (adv)
            begin
                s1_ctl_reg.valid <= s1_valid_next;
                s1_ctl_reg.last  <= last;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_pair_reg <= pair_entry;
        end
    end

    assign mem_we    = accept && col_cur[0] && !row_cur[0];
    assign mem_re    = s1_valid_next;
    assign mem_waddr = col_cur[CW-1:1];
    assign mem_raddr = col_cur[CW-1:1];
    assign mem_wdata = pair_entry;
    assign s1_ctl    = s1_ctl_reg;
    assign s1_pair   = s1_pair_reg;

endmodule

// ===== rtl/core/bhsd_quad_div.sv =====
module bhsd_quad_div #(
    parameter int SAMPLE_BITS = 16,
    parameter int ENTRY_W     = 3 * (SAMPLE_BITS + 1) + 6
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    adv,
    input  bhsd_pkg::bhsd_ctl_t                     s1_ctl,
    input  logic [ENTRY_W-1:0]                      s1_pair,
    input  logic [ENTRY_W-1:0]                      line_entry,
    output logic                                    out_valid,
    output logic [3*bhsd_pkg::FIELD_BITS-1:0]       out_data,
    output logic                                    out_last,
    output logic [1:0]                              out_user
);

    import bhsd_pkg::*;

    localparam int PS_W  = SAMPLE_BITS + 1;
    localparam int SUM_W = SAMPLE_BITS + 2;
    localparam int K     = SUM_W + 1;
    localparam int PR_W  = 2 * SUM_W;
    // floor(x / 3) == (x * RECIP) >> K for every x below 2**SUM_W
    localparam logic [SUM_W-1:0] RECIP = SUM_W'(((64'd1 << K) + 64'd2) / 64'd3);

    logic [2:0][PS_W-1:0]   a_sum;
    logic [2:0][PS_W-1:0]   b_sum;
    logic [2:0][1:0]        a_cnt;
    logic [2:0][1:0]        b_cnt;
    logic [2:0][SUM_W-1:0]  q_sum_next;
    logic [2:0][2:0]        q_cnt_next;
    logic                   missing_next;
    logic                   fail_next;

    logic                   s2_valid_reg;
    logic                   s2_last_reg;
    logic                   s2_missing_reg;
    logic                   s2_failed_reg;
    logic [2:0][SUM_W-1:0]  s2_sum_reg;
    logic [2:0][2:0]        s2_cnt_reg;
    logic                   sticky_reg;

    logic                   s3_valid_reg;
    logic                   s3_last_reg;
    logic                   s3_missing_reg;
    logic                   s3_failed_reg;
    logic [2:0][SUM_W-1:0]  s3_sum_reg;
    logic [2:0][2:0]        s3_cnt_reg;
    logic [2:0][PR_W-1:0]   s3_prod_reg;

    logic [2:0][SAMPLE_BITS-1:0] quot;
    logic [3*FIELD_BITS-1:0]     data_next;

    logic                        out_valid_reg;
    logic                        out_last_reg;
    logic [1:0]                  out_user_reg;
    logic [3*FIELD_BITS-1:0]     out_data_reg;

    always_comb
    begin
        a_sum = s1_pair[3*PS_W-1:0];
        a_cnt = s1_pair[ENTRY_W-1 -: 6];
        b_sum = line_entry[3*PS_W-1:0];
        b_cnt = line_entry[ENTRY_W-1 -: 6];
        missing_next = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            q_sum_next[i] = SUM_W'(a_sum[i]) + SUM_W'(b_sum[i]);
            q_cnt_next[i] = 3'(a_cnt[i]) + 3'(b_cnt[i]);
            if (q_cnt_next[i] == 3'd0)
            begin
                missing_next = 1'b1;
            end
        end
        fail_next = sticky_reg || missing_next;
    end

    // quad sums, colour counts and the frame failure flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            sticky_reg   <= 1'b0;
        end
        else if (adv)
        begin
            s2_valid_reg <= s1_ctl.valid;
            if (s1_ctl.valid)
            begin
                sticky_reg <= s1_ctl.last ? 1'b0 : fail_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_last_reg    <= s1_ctl.last;
            s2_missing_reg <= missing_next;
            s2_failed_reg  <= s1_ctl.last && fail_next;
            s2_sum_reg     <= q_sum_next;
            s2_cnt_reg     <= q_cnt_next;
        end
    end

    // reciprocal products for a count of three
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s3_last_reg    <= s2_last_reg;
            s3_missing_reg <= s2_missing_reg;
            s3_failed_reg  <= s2_failed_reg;
            s3_sum_reg     <= s2_sum_reg;
            s3_cnt_reg     <= s2_cnt_reg;
            for (int i = 0; i < 3; i++)
            begin
                s3_prod_reg[i] <= PR_W'(s2_sum_reg[i]) * PR_W'(RECIP);
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            case (s3_cnt_reg[i])
                3'd1:    quot[i] = s3_sum_reg[i][SAMPLE_BITS-1:0];
                3'd2:    quot[i] = s3_sum_reg[i][SAMPLE_BITS:1];
                3'd3:    quot[i] = s3_prod_reg[i][K +: SAMPLE_BITS];
                3'd4:    quot[i] = s3_sum_reg[i][SAMPLE_BITS+1:2];
                default: quot[i] = '0;
            endcase
        end
        data_next = {FIELD_BITS'(quot[2]), FIELD_BITS'(quot[1]), FIELD_BITS'(quot[0])};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_data_reg <= data_next;
            out_last_reg <= s3_last_reg;
            out_user_reg <= {s3_failed_reg, s3_missing_reg};
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_last  = out_last_reg;
    assign out_user  = out_user_reg;

endmodule

// ===== rtl/core/bayer_half_size_demosaic.sv =====
// pipeline: a quad, once the pixel at its odd row and odd column is taken, moves through
// s1, s2, s3 and the output register; throughput: one raw pixel per cycle, set by the
// single write / single read line memory, while no result waits on the output
// reset: position, pair sums, frame flag and output valid clear at once; registers
// return to their defaults; the line memory is not cleared, as the even row fills it
module bayer_half_size_demosaic #(
    parameter int MAX_WIDTH   = bhsd_pkg::MAX_WIDTH_DEFAULT,
    parameter int SAMPLE_BITS = bhsd_pkg::SAMPLE_BITS_DEFAULT
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // red_sample, green_sample, blue_sample
    input  logic [3*bhsd_pkg::FIELD_BITS-1:0]     s_axis_tdata,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // red_out, green_out, blue_out
    output logic [3*bhsd_pkg::FIELD_BITS-1:0]     m_axis_tdata,
    output logic                                  m_axis_tlast,
    // missing_color, frame_failed
    output logic [1:0]                            m_axis_tuser,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [1:0]                            cfg_index,
    input  logic [bhsd_pkg::PATTERN_BITS-1:0]     cfg_data
);

    import bhsd_pkg::*;

    localparam int ADDR_W  = $clog2(MAX_WIDTH) - 1;
    localparam int ENTRY_W = 3 * (SAMPLE_BITS + 1) + 6;

    logic [PATTERN_BITS-1:0] cfa_pattern_reg;
    logic [WIDTH_BITS-1:0]   image_width_reg;
    logic [HEIGHT_BITS-1:0]  image_height_reg;

    logic                    accept;
    logic                    adv;
    logic                    out_valid;
    logic                    mem_we;
    logic                    mem_re;
    logic [ADDR_W-1:0]       mem_waddr;
    logic [ADDR_W-1:0]       mem_raddr;
    logic [ENTRY_W-1:0]      mem_wdata;
    logic [ENTRY_W-1:0]      mem_rdata;
    bhsd_ctl_t               s1_ctl;
    logic [ENTRY_W-1:0]      s1_pair;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfa_pattern_reg  <= PATTERN_RESET;
            image_width_reg  <= WIDTH_RESET;
            image_height_reg <= HEIGHT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_PATTERN: cfa_pattern_reg  <= cfg_data;
                CFG_WIDTH:   image_width_reg  <= cfg_data[WIDTH_BITS-1:0];
                CFG_HEIGHT:  image_height_reg <= cfg_data[HEIGHT_BITS-1:0];
                default:     ;
            endcase
        end
    end

    // whole pipeline moves unless a result is waiting on the output
    assign adv           = !out_valid || m_axis_tready;
    assign s_axis_tready = adv;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid;

    bhsd_front #(
        .MAX_WIDTH   (MAX_WIDTH),
        .SAMPLE_BITS (SAMPLE_BITS),
        .ADDR_W      (ADDR_W),
        .ENTRY_W     (ENTRY_W)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfa_pattern  (cfa_pattern_reg),
        .image_width  (image_width_reg),
        .image_height (image_height_reg),
        .accept       (accept),
        .adv          (adv),
        .red_sample   (s_axis_tdata[FIELD_BITS-1:0]),
        .green_sample (s_axis_tdata[2*FIELD_BITS-1:FIELD_BITS]),
        .blue_sample  (s_axis_tdata[3*FIELD_BITS-1:2*FIELD_BITS]),
        .mem_we       (mem_we),
        .mem_re       (mem_re),
        .mem_waddr    (mem_waddr),
        .mem_raddr    (mem_raddr),
        .mem_wdata    (mem_wdata),
        .s1_ctl       (s1_ctl),
        .s1_pair      (s1_pair)
    );

    bhsd_line_mem #(
        .ADDR_W (ADDR_W),
        .DATA_W (ENTRY_W)
    ) u_line_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    bhsd_quad_div #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .ENTRY_W     (ENTRY_W)
    ) u_quad_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .s1_ctl     (s1_ctl),
        .s1_pair    (s1_pair),
        .line_entry (mem_rdata),
        .out_valid  (out_valid),
        .out_data   (m_axis_tdata),
        .out_last   (m_axis_tlast),
        .out_user   (m_axis_tuser)
    );

endmodule

// ===== rtl/core/bhsd_checker.sv =====
`include "bayer_half_size_demosaic_macros.svh"

module bhsd_checker (
    input logic                                  clk,
    input logic                                  rst_n,
    input logic                                  m_axis_tvalid,
    input logic                                  m_axis_tready,
    input logic [3*bhsd_pkg::FIELD_BITS-1:0]     m_axis_tdata,
    input logic                                  m_axis_tlast,
    input logic [1:0]                            m_axis_tuser
);

    import bhsd_pkg::*;

    logic out_stall;
    logic any_zero;
    logic failed_out;
    logic last_missing;

    assign out_stall    = m_axis_tvalid && !m_axis_tready;
    assign any_zero     = (m_axis_tdata[FIELD_BITS-1:0] == '0)
                       || (m_axis_tdata[2*FIELD_BITS-1:FIELD_BITS] == '0)
                       || (m_axis_tdata[3*FIELD_BITS-1:2*FIELD_BITS] == '0);
    assign failed_out   = m_axis_tvalid && m_axis_tuser[1];
    assign last_missing = m_axis_tvalid && m_axis_tlast && m_axis_tuser[0];

    // frame failure only shows on the last transaction of a frame
    `BHSD_ASSERT_NOW(a_failed_on_last, clk, rst_n, failed_out, m_axis_tlast)

    // a missing colour on the last quad must fail the frame
    `BHSD_ASSERT_NOW(a_missing_fails, clk, rst_n, last_missing, m_axis_tuser[1])

    // a missing colour reads as zero in its channel
    `BHSD_ASSERT_NOW(a_missing_zero, clk, rst_n, m_axis_tvalid && m_axis_tuser[0], any_zero)

    // a stalled result holds
    `BHSD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_stall, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

endmodule

bind bayer_half_size_demosaic bhsd_checker u_bhsd_checker (.*);
